@@ hw/rtl/rle_enc_pkg.sv @@
`default_nettype none

package rle_enc_pkg;

	// Five decimal digits cover the run cap of 65535.
	localparam int NumDigits = 5;
	localparam int DigitIdxW = $clog2(NumDigits);

	typedef logic [NumDigits-1:0][3:0] bcd_t;
	typedef logic [DigitIdxW-1:0] digit_idx_t;

	// The run cap and the count of a fresh run, both in BCD.
	localparam bcd_t CapBcd = 20'h65535;
	localparam bcd_t OneBcd = 20'h00001;

	localparam logic [3:0] AsciiDigitHi = 4'h3;

	typedef struct packed {
		logic take;
		logic advance;
	} rle_cmd_t;

	typedef struct packed {
		logic starts_group;
		logic at_byte;
		logic pending;
	} rle_sts_t;

endpackage

`default_nettype wire

@@ hw/rtl/rle_enc_ctrl.sv @@
`default_nettype none

module rle_enc_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output rle_enc_pkg::rle_cmd_t     cmd,
	input  wire rle_enc_pkg::rle_sts_t sts
);

	typedef enum logic {
		ST_IDLE,
		ST_EMIT
	} state_t;

	state_t state_q;

	always_comb begin
		in_ready    = (state_q == ST_IDLE);
		out_valid   = (state_q == ST_EMIT);
		cmd.take    = in_ready && in_valid;
		cmd.advance = out_valid && out_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.take && sts.starts_group) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					// A pending single-byte run follows the current group directly.
					if (cmd.advance && sts.at_byte && !sts.pending) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input and output sides open at once");

	a_digit_continues: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.advance && !sts.at_byte) |=> (state_q == ST_EMIT))
		else $error("group ended before its run byte");

	a_silent_item: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.take && !sts.starts_group) |=> in_ready)
		else $error("growing run left the input side closed");

	a_pending_reload: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.advance && sts.at_byte && sts.pending) |=> (out_valid && !sts.at_byte))
		else $error("pending run not emitted after group");

endmodule

`default_nettype wire

@@ hw/rtl/rle_enc_dp.sv @@
`default_nettype none

module rle_enc_dp (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic [7:0]            in_byte,
	input  wire logic                  in_last,
	output logic [7:0]                 out_byte,
	output logic                       out_last,
	input  wire rle_enc_pkg::rle_cmd_t cmd,
	output rle_enc_pkg::rle_sts_t      sts
);

	logic [7:0]              run_byte_q;
	rle_enc_pkg::bcd_t       run_cnt_q;
	logic                    run_open_q;
	rle_enc_pkg::bcd_t       em_cnt_q;
	logic [7:0]              em_byte_q;
	logic                    em_last_q;
	rle_enc_pkg::digit_idx_t idx_q;
	logic                    byte_phase_q;
	logic                    pending_q;

	rle_enc_pkg::bcd_t cnt_inc;
	logic              same;

	function automatic rle_enc_pkg::digit_idx_t msd(input rle_enc_pkg::bcd_t c);
		rle_enc_pkg::digit_idx_t r;
		r = '0;
		for (int i = 0; i < rle_enc_pkg::NumDigits; i++) begin
			if (c[i] != 4'd0) begin
				r = rle_enc_pkg::DigitIdxW'(i);
			end
		end
		return r;
	endfunction

	// BCD increment: a digit wraps from nine to zero and carries.
	always_comb begin
		logic carry;
		carry = 1'b1;
		for (int i = 0; i < rle_enc_pkg::NumDigits; i++) begin
			if (carry && run_cnt_q[i] == 4'd9) begin
				cnt_inc[i] = 4'd0;
			end else begin
				cnt_inc[i] = run_cnt_q[i] + {3'd0, carry};
				carry = 1'b0;
			end
		end
	end

	assign same = run_open_q && (in_byte == run_byte_q) && (run_cnt_q != rle_enc_pkg::CapBcd);

	always_comb begin
		sts.starts_group = in_last || (run_open_q && !same);
		sts.at_byte      = byte_phase_q;
		sts.pending      = pending_q;
		out_last         = byte_phase_q && em_last_q;
		out_byte         = byte_phase_q ? em_byte_q
		                                : {rle_enc_pkg::AsciiDigitHi, em_cnt_q[idx_q]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_byte_q   <= '0;
			run_cnt_q    <= '0;
			run_open_q   <= 1'b0;
			idx_q        <= '0;
			byte_phase_q <= 1'b0;
			pending_q    <= 1'b0;
		end else if (cmd.take) begin
			run_open_q <= !in_last;
			if (same) begin
				run_cnt_q <= cnt_inc;
				if (in_last) begin
					idx_q        <= msd(cnt_inc);
					byte_phase_q <= 1'b0;
				end
			end else begin
				run_byte_q <= in_byte;
				run_cnt_q  <= rle_enc_pkg::OneBcd;
				if (run_open_q) begin
					idx_q        <= msd(run_cnt_q);
					byte_phase_q <= 1'b0;
					pending_q    <= in_last;
				end else if (in_last) begin
					idx_q        <= '0;
					byte_phase_q <= 1'b0;
				end
			end
		end else if (cmd.advance) begin
			if (byte_phase_q) begin
				if (pending_q) begin
					// The new run is a single byte and holds a count of one.
					idx_q        <= '0;
					byte_phase_q <= 1'b0;
					pending_q    <= 1'b0;
				end
			end else if (idx_q == '0) begin
				byte_phase_q <= 1'b1;
			end else begin
				idx_q <= idx_q - 1'b1;
			end
		end
	end

	// Group payload; it is only read while a group is being emitted.
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			if (same) begin
				if (in_last) begin
					em_cnt_q  <= cnt_inc;
					em_byte_q <= run_byte_q;
					em_last_q <= 1'b1;
				end
			end else if (run_open_q) begin
				em_cnt_q  <= run_cnt_q;
				em_byte_q <= run_byte_q;
				em_last_q <= 1'b0;
			end else if (in_last) begin
				em_cnt_q  <= rle_enc_pkg::OneBcd;
				em_byte_q <= in_byte;
				em_last_q <= 1'b1;
			end
		end else if (cmd.advance && byte_phase_q && pending_q) begin
			em_cnt_q  <= rle_enc_pkg::OneBcd;
			em_byte_q <= run_byte_q;
			em_last_q <= 1'b1;
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/rle_text_encoder_unit.sv @@
`default_nettype none

// Channel  | Signals                            | Direction
// ---------+------------------------------------+----------
// input    | in_valid, in_ready, in_byte, in_last  | in
// output   | out_valid, out_ready, out_byte, out_last | out
//
// A byte that only grows the run is taken without output. An item that closes a run
// starts a run group of output beats: its digits (one to five) and the run byte, plus
// one digit and one byte more when a single-byte final run follows. The run count is
// held in BCD and the group is sent one digit per beat. Reset clears the open run and
// returns to taking input.
// While output is stalled the group holds and no input beat is taken.

module rle_text_encoder_unit (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] in_byte,
	input  wire logic       in_last,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      out_byte,
	output logic            out_last
);

	rle_enc_pkg::rle_cmd_t cmd;
	rle_enc_pkg::rle_sts_t sts;

	rle_enc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	rle_enc_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_byte  (in_byte),
		.in_last  (in_last),
		.out_byte (out_byte),
		.out_last (out_last),
		.cmd      (cmd),
		.sts      (sts)
	);

endmodule

`default_nettype wire
